>>> rtl/cst_pkg.sv
// ---------------------------------------------------------------------------
// cst_pkg
// Shared types and constants of the C subset tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none
package cst_pkg;
   localparam int POSITION_BITS_DEF = 16;
   localparam int VALUE_BITS_DEF = 16;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [3:0] {
      PH_IDLE, PH_SLASH, PH_LINE, PH_BLOCK, PH_BSTAR, PH_IDENT, PH_ZERO,
      PH_DEC, PH_HEX, PH_CHOPEN, PH_CHCLOSE, PH_STR, PH_OP
   } phase_type;

   localparam logic [2:0] KIND_EOF = 3'd0;
   localparam logic [2:0] KIND_NUM = 3'd1;
   localparam logic [2:0] KIND_IDENT = 3'd2;
   localparam logic [2:0] KIND_KEYWORD = 3'd3;
   localparam logic [2:0] KIND_STRING = 3'd4;
   localparam logic [2:0] KIND_PUNCT = 3'd5;

   // one byte as classified by the front part
   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_end;
      logic       fin;
      logic       is_letter;
      logic       is_decimal;
      logic       is_hex;
      logic [3:0] hex_value;
      logic       is_space;
   } class_type;

   function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] i);
      logic [55:0] s;
      case (k)
         4'd0: s = {"int", 32'h0};
         4'd1: s = {"char", 24'h0};
         4'd2: s = {"void", 24'h0};
         4'd3: s = {"struct", 8'h0};
         4'd4: s = {"union", 16'h0};
         4'd5: s = {"if", 40'h0};
         4'd6: s = {"else", 24'h0};
         4'd7: s = {"while", 16'h0};
         4'd8: s = {"for", 32'h0};
         4'd9: s = {"return", 8'h0};
         default: s = '0;
      endcase
      kw_char = s[55 - 8*i -: 8];
   endfunction

   function automatic logic [2:0] kw_len(input logic [3:0] k);
      case (k)
         4'd0: kw_len = 3'd3;
         4'd1: kw_len = 3'd4;
         4'd2: kw_len = 3'd4;
         4'd3: kw_len = 3'd6;
         4'd4: kw_len = 3'd5;
         4'd5: kw_len = 3'd2;
         4'd6: kw_len = 3'd4;
         4'd7: kw_len = 3'd5;
         4'd8: kw_len = 3'd3;
         4'd9: kw_len = 3'd6;
         default: kw_len = 3'd0;
      endcase
   endfunction

   function automatic logic op_pair(input logic [7:0] a, input logic [7:0] b);
      op_pair = (a == 8'd61 && b == 8'd61) || (a == 8'd33 && b == 8'd61) ||
                (a == 8'd60 && b == 8'd61) || (a == 8'd62 && b == 8'd61) ||
                (a == 8'd60 && b == 8'd60) || (a == 8'd62 && b == 8'd62) ||
                (a == 8'd38 && b == 8'd38) || (a == 8'd124 && b == 8'd124) ||
                (a == 8'd45 && b == 8'd62);
   endfunction
endpackage
`default_nettype wire

>>> rtl/cst_if.sv
// ---------------------------------------------------------------------------
// cst_req_if / cst_rsp_if
// Valid/ready channels for source bytes and tokens.
// ---------------------------------------------------------------------------
`default_nettype none
interface cst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last;
   modport source(output valid, in_byte, last, input ready);
   modport sink(input valid, in_byte, last, output ready);
endinterface

interface cst_rsp_if #(parameter int POSITION_BITS = 16, parameter int VALUE_BITS = 16);
   logic                     valid;
   logic                     ready;
   logic [2:0]               token_kind;
   logic [VALUE_BITS-1:0]    number_value;
   logic [3:0]               keyword_index;
   logic [7:0]               punct_first;
   logic [7:0]               punct_second;
   logic [POSITION_BITS-1:0] token_start;
   logic [15:0]              token_length;
   logic                     last_of_run;
   modport source(output valid, token_kind, number_value, keyword_index, punct_first,
                  punct_second, token_start, token_length, last_of_run, input ready);
   modport sink(input valid, token_kind, number_value, keyword_index, punct_first,
                punct_second, token_start, token_length, last_of_run, output ready);
endinterface
`default_nettype wire

>>> rtl/cst_front.sv
// ---------------------------------------------------------------------------
// cst_front
// Accepts source bytes, classifies them and queues them for the scanner.
// ---------------------------------------------------------------------------
`default_nettype none
module cst_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_in_byte,
   input  wire logic               req_last,
   output logic                    q_valid,
   input  wire logic               q_pop,
   output cst_pkg::class_type      q_data
);
   localparam int D = cst_pkg::QUEUE_DEPTH;
   localparam int AW = $clog2(D);

   cst_pkg::class_type mem_ff [D];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   cst_pkg::class_type cls;
   logic push;
   logic [7:0] c;

   always_comb begin
      c = req_in_byte;
      cls.in_byte = c;
      cls.is_end = (c == 8'd0);
      cls.fin = req_last;
      cls.is_letter = (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122) ||
                      c == 8'd95;
      cls.is_decimal = (c >= 8'd48 && c <= 8'd57);
      cls.is_hex = cls.is_decimal || (c >= 8'd97 && c <= 8'd102) ||
                   (c >= 8'd65 && c <= 8'd70);
      if (c <= 8'd57) cls.hex_value = 4'(c - 8'd48);
      else if (c <= 8'd70) cls.hex_value = 4'(c - 8'd55);
      else cls.hex_value = 4'(c - 8'd87);
      cls.is_space = c == 8'd32 || c == 8'd9 || c == 8'd13 || c == 8'd10;
   end

   assign req_ready = (cnt_ff != (AW+1)'(D));
   assign push = req_valid && req_ready;
   assign q_valid = (cnt_ff != '0);
   assign q_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = q_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= cls;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/cst_back.sv
// ---------------------------------------------------------------------------
// cst_back
// Scanner: runs the token state machine on one queued byte per cycle when
// free, and serializes up to three tokens per byte through an output register.
// ---------------------------------------------------------------------------
`default_nettype none
module cst_back #(
   parameter int POSITION_BITS = cst_pkg::POSITION_BITS_DEF,
   parameter int VALUE_BITS = cst_pkg::VALUE_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   output logic               q_pop,
   input  cst_pkg::class_type q_data,
   cst_rsp_if.source          rsp
);
   typedef struct packed {
      logic [2:0]               kind;
      logic [VALUE_BITS-1:0]    val;
      logic [3:0]               kw;
      logic [7:0]               p1;
      logic [7:0]               p2;
      logic [POSITION_BITS-1:0] start;
      logic [15:0]              len;
   } tok_type;

   cst_pkg::phase_type phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic [POSITION_BITS-1:0] rpos_ff, rpos_in, spos_ff, spos_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [9:0] cand_ff, cand_in;
   logic esc_ff, esc_in;
   logic [15:0] len_ff, len_in;

   // pending tokens of the byte being emitted
   tok_type pend_ff [3];
   tok_type pend_in [3];
   logic [1:0] pcnt_ff, pcnt_in, pidx_ff, pidx_in;
   logic busy_ff, busy_in;

   tok_type out_ff;
   logic out_valid_ff, out_last_ff;

   tok_type toks [3];
   logic [1:0] ntok;
   logic [7:0] c;
   logic again;
   logic take;
   logic out_free;

   function automatic logic [9:0] filter(input logic [9:0] cand, input logic [15:0] l,
                                         input logic [7:0] ch);
      logic [9:0] r;
      r = cand;
      for (int k = 0; k < 10; k++) begin
         if (l >= 16'(cst_pkg::kw_len(4'(k))) ||
             cst_pkg::kw_char(4'(k), l[2:0]) != ch) r[k] = 1'b0;
      end
      return r;
   endfunction

   function automatic tok_type mk(input logic [2:0] kind, input logic [VALUE_BITS-1:0] v,
                                  input logic [3:0] kw, input logic [7:0] a,
                                  input logic [7:0] b, input logic [POSITION_BITS-1:0] s,
                                  input logic [15:0] l);
      tok_type t;
      t.kind = kind; t.val = v; t.kw = kw; t.p1 = a; t.p2 = b; t.start = s; t.len = l;
      return t;
   endfunction

   assign out_free = !out_valid_ff || rsp.ready;
   assign take = q_valid && !busy_ff && out_free;
   assign q_pop = take;
   assign c = q_data.in_byte;

   always_comb begin
      tok_type ft;
      logic fv;
      logic [3:0] kwi;
      logic kwf;
      logic [15:0] grown;
      phase_in = phase_ff; held_in = held_ff; rpos_in = rpos_ff; spos_in = spos_ff;
      acc_in = acc_ff; cand_in = cand_ff; esc_in = esc_ff; len_in = len_ff;
      ntok = '0; again = 1'b0;
      for (int i = 0; i < 3; i++) toks[i] = '0;
      ft = '0; fv = 1'b0; kwi = '0; kwf = 1'b0;
      grown = (len_ff == 16'hFFFF) ? len_ff : len_ff + 16'd1;
      // flush token of the current open phase
      for (int k = 9; k >= 0; k--) begin
         if (cand_ff[k] && len_ff == 16'(cst_pkg::kw_len(4'(k)))) begin
            kwf = 1'b1; kwi = 4'(k);
         end
      end
      unique case (phase_ff)
         cst_pkg::PH_SLASH: begin
            fv = 1'b1; ft = mk(cst_pkg::KIND_PUNCT, '0, '0, 8'd47, '0, spos_ff, len_ff);
         end
         cst_pkg::PH_OP: begin
            fv = 1'b1; ft = mk(cst_pkg::KIND_PUNCT, '0, '0, held_ff, '0, spos_ff, len_ff);
         end
         cst_pkg::PH_IDENT: begin
            fv = 1'b1;
            ft = kwf ? mk(cst_pkg::KIND_KEYWORD, '0, kwi, '0, '0, spos_ff, len_ff)
                     : mk(cst_pkg::KIND_IDENT, '0, '0, '0, '0, spos_ff, len_ff);
         end
         cst_pkg::PH_ZERO, cst_pkg::PH_DEC, cst_pkg::PH_HEX, cst_pkg::PH_CHOPEN,
         cst_pkg::PH_CHCLOSE: begin
            fv = 1'b1; ft = mk(cst_pkg::KIND_NUM, acc_ff, '0, '0, '0, spos_ff, len_ff);
         end
         cst_pkg::PH_STR: begin
            fv = 1'b1; ft = mk(cst_pkg::KIND_STRING, '0, '0, '0, '0, spos_ff, len_ff);
         end
         default: ;
      endcase

      if (!q_data.is_end) begin
         // first pass in the open phase
         unique case (phase_ff)
            cst_pkg::PH_IDLE: again = 1'b1;
            cst_pkg::PH_SLASH:
               if (c == 8'd47) phase_in = cst_pkg::PH_LINE;
               else if (c == 8'd42) phase_in = cst_pkg::PH_BLOCK;
               else again = 1'b1;
            cst_pkg::PH_LINE: if (c == 8'd10) phase_in = cst_pkg::PH_IDLE;
            cst_pkg::PH_BLOCK: if (c == 8'd42) phase_in = cst_pkg::PH_BSTAR;
            cst_pkg::PH_BSTAR:
               if (c == 8'd47) phase_in = cst_pkg::PH_IDLE;
               else if (c != 8'd42) phase_in = cst_pkg::PH_BLOCK;
            cst_pkg::PH_IDENT:
               if (q_data.is_letter || q_data.is_decimal) begin
                  cand_in = filter(cand_ff, len_ff, c); len_in = grown;
               end else again = 1'b1;
            cst_pkg::PH_ZERO:
               if (c == 8'd120 || c == 8'd88) begin
                  phase_in = cst_pkg::PH_HEX; len_in = grown;
               end else if (q_data.is_decimal) begin
                  phase_in = cst_pkg::PH_DEC; acc_in = VALUE_BITS'(c - 8'd48);
                  len_in = grown;
               end else again = 1'b1;
            cst_pkg::PH_DEC:
               if (q_data.is_decimal) begin
                  acc_in = VALUE_BITS'((acc_ff << 3) + (acc_ff << 1) +
                                       VALUE_BITS'(c - 8'd48));
                  len_in = grown;
               end else again = 1'b1;
            cst_pkg::PH_HEX:
               if (q_data.is_hex) begin
                  acc_in = VALUE_BITS'({acc_ff, 4'h0} | VALUE_BITS'(q_data.hex_value));
                  len_in = grown;
               end else again = 1'b1;
            cst_pkg::PH_CHOPEN: begin
               len_in = grown;
               if (esc_ff) begin
                  if (c == 8'd110) acc_in = VALUE_BITS'(8'd10);
                  else if (c == 8'd116) acc_in = VALUE_BITS'(8'd9);
                  else if (c == 8'd114) acc_in = VALUE_BITS'(8'd13);
                  else if (c == 8'd48) acc_in = '0;
                  else acc_in = VALUE_BITS'(c);
                  esc_in = 1'b0; phase_in = cst_pkg::PH_CHCLOSE;
               end else if (c == 8'd92) esc_in = 1'b1;
               else begin
                  acc_in = VALUE_BITS'(c); phase_in = cst_pkg::PH_CHCLOSE;
               end
            end
            cst_pkg::PH_CHCLOSE:
               if (c == 8'd39) begin
                  toks[0] = mk(cst_pkg::KIND_NUM, acc_ff, '0, '0, '0, spos_ff, grown);
                  ntok = 2'd1; phase_in = cst_pkg::PH_IDLE; esc_in = 1'b0;
               end else again = 1'b1;
            cst_pkg::PH_STR: begin
               len_in = grown;
               if (esc_ff) esc_in = 1'b0;
               else if (c == 8'd92) esc_in = 1'b1;
               else if (c == 8'd34) begin
                  toks[0] = mk(cst_pkg::KIND_STRING, '0, '0, '0, '0, spos_ff, grown);
                  ntok = 2'd1; phase_in = cst_pkg::PH_IDLE;
               end
            end
            cst_pkg::PH_OP:
               if (cst_pkg::op_pair(held_ff, c)) begin
                  toks[0] = mk(cst_pkg::KIND_PUNCT, '0, '0, held_ff, c, spos_ff, 16'd2);
                  ntok = 2'd1; phase_in = cst_pkg::PH_IDLE;
               end else again = 1'b1;
            default: begin
               phase_in = cst_pkg::PH_IDLE; again = 1'b1;
            end
         endcase
         if (again) begin
            if (fv) begin
               toks[0] = ft; ntok = 2'd1;
            end
            phase_in = cst_pkg::PH_IDLE; esc_in = 1'b0;
            // idle handling of the byte
            if (q_data.is_space) ;
            else if (c == 8'd35) phase_in = cst_pkg::PH_LINE;
            else if (c == 8'd47) begin
               phase_in = cst_pkg::PH_SLASH; spos_in = rpos_ff; len_in = 16'd1;
               acc_in = '0; held_in = c;
            end else if (q_data.is_letter) begin
               phase_in = cst_pkg::PH_IDENT; spos_in = rpos_ff; acc_in = '0;
               cand_in = filter(10'h3FF, 16'd0, c); len_in = 16'd1;
            end else if (q_data.is_decimal) begin
               phase_in = (c == 8'd48) ? cst_pkg::PH_ZERO : cst_pkg::PH_DEC;
               spos_in = rpos_ff; len_in = 16'd1; acc_in = VALUE_BITS'(c - 8'd48);
            end else if (c == 8'd39) begin
               phase_in = cst_pkg::PH_CHOPEN; spos_in = rpos_ff; len_in = 16'd1;
               acc_in = '0;
            end else if (c == 8'd34) begin
               phase_in = cst_pkg::PH_STR; spos_in = rpos_ff; len_in = 16'd1; acc_in = '0;
            end else if (c == 8'd61 || c == 8'd33 || c == 8'd60 || c == 8'd62 ||
                         c == 8'd38 || c == 8'd124 || c == 8'd45) begin
               phase_in = cst_pkg::PH_OP; spos_in = rpos_ff; len_in = 16'd1;
               acc_in = '0; held_in = c;
            end else begin
               toks[ntok] = mk(cst_pkg::KIND_PUNCT, '0, '0, c, '0, rpos_ff, 16'd1);
               ntok = ntok + 2'd1;
            end
         end
         rpos_in = rpos_ff + 1'b1;
      end

      if (q_data.is_end || q_data.fin) begin
         // flush whatever the byte left open, then eof, then reset state
         unique case (phase_in)
            cst_pkg::PH_SLASH, cst_pkg::PH_OP: begin
               toks[ntok] = mk(cst_pkg::KIND_PUNCT, '0, '0, held_in, '0, spos_in, len_in);
               ntok = ntok + 2'd1;
            end
            cst_pkg::PH_IDENT: begin
               kwf = 1'b0; kwi = '0;
               for (int k = 9; k >= 0; k--) begin
                  if (cand_in[k] && len_in == 16'(cst_pkg::kw_len(4'(k)))) begin
                     kwf = 1'b1; kwi = 4'(k);
                  end
               end
               toks[ntok] = kwf ? mk(cst_pkg::KIND_KEYWORD, '0, kwi, '0, '0, spos_in, len_in)
                                : mk(cst_pkg::KIND_IDENT, '0, '0, '0, '0, spos_in, len_in);
               ntok = ntok + 2'd1;
            end
            cst_pkg::PH_ZERO, cst_pkg::PH_DEC, cst_pkg::PH_HEX, cst_pkg::PH_CHOPEN,
            cst_pkg::PH_CHCLOSE: begin
               toks[ntok] = mk(cst_pkg::KIND_NUM, acc_in, '0, '0, '0, spos_in, len_in);
               ntok = ntok + 2'd1;
            end
            cst_pkg::PH_STR: begin
               toks[ntok] = mk(cst_pkg::KIND_STRING, '0, '0, '0, '0, spos_in, len_in);
               ntok = ntok + 2'd1;
            end
            default: ;
         endcase
         toks[ntok] = mk(cst_pkg::KIND_EOF, '0, '0, '0, '0, rpos_in, '0);
         ntok = ntok + 2'd1;
         phase_in = cst_pkg::PH_IDLE; held_in = '0; rpos_in = '0; spos_in = '0;
         acc_in = '0; cand_in = 10'h3FF; esc_in = 1'b0; len_in = '0;
      end
   end

   // emission: first token goes to the output register at once, the rest
   // drain from the pending buffer one per cycle while the output is free
   always_comb begin
      busy_in = busy_ff; pidx_in = pidx_ff; pcnt_in = pcnt_ff;
      for (int i = 0; i < 3; i++) pend_in[i] = pend_ff[i];
      if (take) begin
         for (int i = 0; i < 3; i++) pend_in[i] = toks[i];
         pcnt_in = ntok; pidx_in = 2'd1;
         busy_in = (ntok > 2'd1);
      end else if (busy_ff && out_free) begin
         pidx_in = pidx_ff + 2'd1;
         busy_in = (pidx_ff + 2'd1 < pcnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cst_pkg::PH_IDLE; held_ff <= '0; rpos_ff <= '0; spos_ff <= '0;
         acc_ff <= '0; cand_ff <= 10'h3FF; esc_ff <= 1'b0; len_ff <= '0;
         busy_ff <= 1'b0; pidx_ff <= '0; pcnt_ff <= '0; out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in; held_ff <= held_in; rpos_ff <= rpos_in;
            spos_ff <= spos_in; acc_ff <= acc_in; cand_ff <= cand_in;
            esc_ff <= esc_in; len_ff <= len_in;
         end
         busy_ff <= busy_in; pidx_ff <= pidx_in; pcnt_ff <= pcnt_in;
         if (take) out_valid_ff <= (ntok != 2'd0);
         else if (busy_ff && out_free) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) pend_ff[i] <= pend_in[i];
      if (take) begin
         out_ff <= toks[0];
         out_last_ff <= (ntok == 2'd1);
      end else if (busy_ff && out_free) begin
         out_ff <= pend_ff[pidx_ff];
         out_last_ff <= (pidx_ff + 2'd1 == pcnt_ff);
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.token_kind = out_ff.kind;
   assign rsp.number_value = out_ff.val;
   assign rsp.keyword_index = out_ff.kw;
   assign rsp.punct_first = out_ff.p1;
   assign rsp.punct_second = out_ff.p2;
   assign rsp.token_start = out_ff.start;
   assign rsp.token_length = out_ff.len;
   assign rsp.last_of_run = out_last_ff;
endmodule
`default_nettype wire

>>> rtl/c_subset_tokenizer.sv
// ---------------------------------------------------------------------------
// c_subset_tokenizer
// Streaming lexer for a small C subset: bytes in, tokens out.
// ---------------------------------------------------------------------------
// path: an accepted byte is registered in the byte queue, then its first token
//   is registered in the output register
// throughput: one byte per cycle while tokens are taken; a byte with more than
//   one token holds the scanner until its tokens drain, one per cycle as taken
// reset: synchronous, clears the byte queue, scanner state and output
`default_nettype none
module c_subset_tokenizer #(
   parameter int POSITION_BITS = cst_pkg::POSITION_BITS_DEF,
   parameter int VALUE_BITS = cst_pkg::VALUE_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   cst_req_if.sink   req,
   cst_rsp_if.source rsp
);
   logic q_valid, q_pop;
   cst_pkg::class_type q_data;

   cst_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .req_in_byte(req.in_byte), .req_last(req.last),
      .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
   );

   cst_back #(.POSITION_BITS(POSITION_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data), .rsp(rsp)
   );
endmodule
`default_nettype wire

>>> test/tb_c_subset_tokenizer.sv
// ---------------------------------------------------------------------------
// tb_c_subset_tokenizer
// Self-checking bench for the C subset tokenizer: random and directed
// source text is driven byte by byte, tokens are predicted and compared.
// ---------------------------------------------------------------------------
module tb_c_subset_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] value;
      logic [3:0]  kw;
      logic [7:0]  p1;
      logic [7:0]  p2;
      logic [15:0] start;
      logic [15:0] len;
      logic        lastrun;
   } token_type;

   typedef struct packed {
      logic [7:0] b;
      logic       fin;
   } src_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cst_req_if req ();
   cst_rsp_if rsp ();

   c_subset_tokenizer i_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   src_type   pending_bytes[$];
   token_type expected_tokens[$];
   int     error_count = 0;
   int     idle_cycles = 0;
   int     send_idle_pct = 0;
   int     recv_stall_pct = 0;
   bit     hold_start = 1'b0;
   bit     hold_active;

   // lexer state mirrored at the block's widths
   cst_pkg::phase_type lx_phase;
   logic [7:0]  lx_held;
   logic [15:0] lx_pos, lx_start, lx_acc, lx_len;
   logic [9:0]  lx_cand;
   logic        lx_esc;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void lexer_reset();
      lx_phase = cst_pkg::PH_IDLE;
      lx_held = 8'd0;
      lx_pos = '0;
      lx_start = '0;
      lx_acc = '0;
      lx_cand = 10'h3FF;
      lx_esc = 1'b0;
      lx_len = '0;
   endfunction

   function automatic void push_token(logic [2:0] k, logic [15:0] v, logic [3:0] kw,
                                      logic [7:0] a, logic [7:0] b, logic [15:0] s,
                                      logic [15:0] l);
      token_type t;
      t = '{k, v, kw, a, b, s, l, 1'b0};
      expected_tokens.push_back(t);
   endfunction

   function automatic bit letter_byte(logic [7:0] c);
      return (c >= 65 && c <= 90) || (c >= 97 && c <= 122) || c == 95;
   endfunction

   function automatic bit is_num(logic [7:0] c);
      return c >= 48 && c <= 57;
   endfunction

   function automatic logic [7:0] keyword_char(int k, int i);
      string words[10] = '{"int", "char", "void", "struct", "union",
                           "if", "else", "while", "for", "return"};
      if (i >= words[k].len()) return 8'd0;
      return words[k][i];
   endfunction

   function automatic int keyword_size(int k);
      int sizes[10] = '{3, 4, 4, 6, 5, 2, 4, 5, 3, 6};
      return sizes[k];
   endfunction

   function automatic void narrow_keywords(logic [7:0] c);
      for (int k = 0; k < 10; k++)
         if (lx_cand[k] && (lx_len >= keyword_size(k) || keyword_char(k, lx_len) != c))
            lx_cand[k] = 1'b0;
   endfunction

   function automatic void lengthen();
      if (lx_len != 16'hFFFF) lx_len++;
   endfunction

   function automatic void close_token();
      int k;
      case (lx_phase)
         cst_pkg::PH_SLASH:
            push_token(cst_pkg::KIND_PUNCT, 0, 0, 8'd47, 0, lx_start, lx_len);
         cst_pkg::PH_OP:
            push_token(cst_pkg::KIND_PUNCT, 0, 0, lx_held, 0, lx_start, lx_len);
         cst_pkg::PH_IDENT: begin
            for (k = 0; k < 10; k++)
               if (lx_cand[k] && lx_len == keyword_size(k)) break;
            if (k < 10) push_token(cst_pkg::KIND_KEYWORD, 0, k, 0, 0, lx_start, lx_len);
            else push_token(cst_pkg::KIND_IDENT, 0, 0, 0, 0, lx_start, lx_len);
         end
         cst_pkg::PH_ZERO, cst_pkg::PH_DEC, cst_pkg::PH_HEX, cst_pkg::PH_CHOPEN,
         cst_pkg::PH_CHCLOSE:
            push_token(cst_pkg::KIND_NUM, lx_acc, 0, 0, 0, lx_start, lx_len);
         cst_pkg::PH_STR:
            push_token(cst_pkg::KIND_STRING, 0, 0, 0, 0, lx_start, lx_len);
         default: ;
      endcase
      lx_phase = cst_pkg::PH_IDLE;
      lx_esc = 1'b0;
   endfunction

   function automatic void open_token(cst_pkg::phase_type ph);
      lx_phase = ph;
      lx_start = lx_pos;
      lx_len = 1;
      lx_acc = 0;
   endfunction

   function automatic void scan_idle(logic [7:0] c);
      if (c == 32 || c == 9 || c == 13 || c == 10) return;
      if (c == 35) lx_phase = cst_pkg::PH_LINE;
      else if (c == 47) begin
         open_token(cst_pkg::PH_SLASH);
         lx_held = 8'd47;
      end else if (letter_byte(c)) begin
         open_token(cst_pkg::PH_IDENT);
         lx_cand = 10'h3FF;
         lx_len = 0;
         narrow_keywords(c);
         lx_len = 1;
      end else if (is_num(c)) begin
         open_token(c == 48 ? cst_pkg::PH_ZERO : cst_pkg::PH_DEC);
         lx_acc = c - 48;
      end else if (c == 39) begin
         open_token(cst_pkg::PH_CHOPEN);
         lx_esc = 1'b0;
      end else if (c == 34) begin
         open_token(cst_pkg::PH_STR);
         lx_esc = 1'b0;
      end else if (c == 61 || c == 33 || c == 60 || c == 62 || c == 38 || c == 124
                   || c == 45) begin
         open_token(cst_pkg::PH_OP);
         lx_held = c;
      end else push_token(cst_pkg::KIND_PUNCT, 0, 0, c, 0, lx_pos, 1);
   endfunction

   function automatic logic [3:0] hex_digit(logic [7:0] c);
      if (c <= 57) return 4'(c - 48);
      if (c <= 70) return 4'(c - 55);
      return 4'(c - 87);
   endfunction

   function automatic void scan_byte(logic [7:0] c);
      bit again;
      for (int pass = 0; pass < 2; pass++) begin
         again = 0;
         case (lx_phase)
            cst_pkg::PH_IDLE: scan_idle(c);
            cst_pkg::PH_SLASH:
               if (c == 47) lx_phase = cst_pkg::PH_LINE;
               else if (c == 42) lx_phase = cst_pkg::PH_BLOCK;
               else begin close_token(); again = 1; end
            cst_pkg::PH_LINE: if (c == 10) lx_phase = cst_pkg::PH_IDLE;
            cst_pkg::PH_BLOCK: if (c == 42) lx_phase = cst_pkg::PH_BSTAR;
            cst_pkg::PH_BSTAR:
               if (c == 47) lx_phase = cst_pkg::PH_IDLE;
               else if (c != 42) lx_phase = cst_pkg::PH_BLOCK;
            cst_pkg::PH_IDENT:
               if (letter_byte(c) || is_num(c)) begin narrow_keywords(c); lengthen(); end
               else begin close_token(); again = 1; end
            cst_pkg::PH_ZERO:
               if (c == 120 || c == 88) begin lx_phase = cst_pkg::PH_HEX; lengthen(); end
               else if (is_num(c)) begin
                  lx_phase = cst_pkg::PH_DEC;
                  lx_acc = c - 48;
                  lengthen();
               end else begin close_token(); again = 1; end
            cst_pkg::PH_DEC:
               if (is_num(c)) begin lx_acc = lx_acc * 10 + (c - 48); lengthen(); end
               else begin close_token(); again = 1; end
            cst_pkg::PH_HEX:
               if (is_num(c) || (c >= 97 && c <= 102) || (c >= 65 && c <= 70)) begin
                  lx_acc = lx_acc * 16 + hex_digit(c);
                  lengthen();
               end else begin close_token(); again = 1; end
            cst_pkg::PH_CHOPEN: begin
               lengthen();
               if (lx_esc) begin
                  case (c)
                     8'd110:  lx_acc = 10;
                     8'd116:  lx_acc = 9;
                     8'd114:  lx_acc = 13;
                     8'd48:   lx_acc = 0;
                     default: lx_acc = c;
                  endcase
                  lx_esc = 1'b0;
                  lx_phase = cst_pkg::PH_CHCLOSE;
               end else if (c == 92) lx_esc = 1'b1;
               else begin lx_acc = c; lx_phase = cst_pkg::PH_CHCLOSE; end
            end
            cst_pkg::PH_CHCLOSE:
               if (c == 39) begin lengthen(); close_token(); end
               else begin close_token(); again = 1; end
            cst_pkg::PH_STR: begin
               lengthen();
               if (lx_esc) lx_esc = 1'b0;
               else if (c == 92) lx_esc = 1'b1;
               else if (c == 34) close_token();
            end
            cst_pkg::PH_OP:
               if (cst_pkg::op_pair(lx_held, c)) begin
                  push_token(cst_pkg::KIND_PUNCT, 0, 0, lx_held, c, lx_start, 2);
                  lx_phase = cst_pkg::PH_IDLE;
               end else begin close_token(); again = 1; end
            default: begin lx_phase = cst_pkg::PH_IDLE; again = 1; end
         endcase
         if (!again) break;
      end
      lx_pos++;
   endfunction

   function automatic void predict_tokens(src_type s);
      int before_n;
      before_n = expected_tokens.size();
      if (s.b != 0) scan_byte(s.b);
      if (s.b == 0 || s.fin) begin
         close_token();
         push_token(cst_pkg::KIND_EOF, 0, 0, 0, 0, lx_pos, 0);
         lexer_reset();
      end
      if (expected_tokens.size() > before_n)
         expected_tokens[expected_tokens.size() - 1].lastrun = 1'b1;
   endfunction

   task automatic report_mismatch(string what, token_type got, token_type want);
      $display("mismatch %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   task automatic add_text(string s, bit fin);
      for (int i = 0; i < s.len(); i++)
         pending_bytes.push_back('{s[i], fin && i == s.len() - 1});
   endtask

   function automatic logic [7:0] pick_byte();
      string alpha = "abcdefghijklmnopqrstuvwxyzABCDEFXZ_0123456789";
      string punc = "=!<>&|-+*/;(){}[],.'\"\\#x \n\t";
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return alpha[$urandom_range(0, alpha.len() - 1)];
         4, 5, 6, 7: return punc[$urandom_range(0, punc.len() - 1)];
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   task automatic add_random_source();
      string kws[14] = '{"int ", "char ", "void ", "struct ", "union ", "if(", "else ",
                         "while ", "for ", "return ", "0x1fF ", "'\\n'", "\"a\\\"b\" ",
                         "/* c */"};
      int n;
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0) add_text(kws[$urandom_range(0, 13)], 0);
         else pending_bytes.push_back('{pick_byte(), 1'b0});
      end
      case ($urandom_range(0, 2))
         0: pending_bytes.push_back('{8'd0, 1'($urandom_range(0, 1))});
         1: pending_bytes.push_back('{pick_byte(), 1'b1});
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.in_byte <= 8'd0;
         req.last <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            predict_tokens('{req.in_byte, req.last});
         end
         if ((!req.valid || req.ready) ) begin
            if (pending_bytes.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
               src_type s;
               s = pending_bytes.pop_front();
               req.valid <= 1'b1;
               req.in_byte <= s.b;
               req.last <= s.fin;
            end else req.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, started once by the stimulus
   initial begin
      hold_active = 1'b0;
      wait (hold_start);
      @(posedge clock);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   // monitor
   always @(posedge clock) begin
      token_type got, want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.token_kind, rsp.number_value, rsp.keyword_index, rsp.punct_first,
                    rsp.punct_second, rsp.token_start, rsp.token_length, rsp.last_of_run};
            if (expected_tokens.size() == 0) report_mismatch("unexpected word", got, got);
            else begin
               want = expected_tokens.pop_front();
               if (got !== want) report_mismatch("token", got, want);
            end
         end
         if (hold_active) rsp.ready <= 1'b0;
         else rsp.ready <= ($urandom_range(1, 100) > recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || hold_active)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_c_subset_tokenizer NOT OK");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_bytes.size() > 0 || req.valid || expected_tokens.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      lexer_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed text: keywords, operators, literals, comments, odd ends
      add_text("int char void struct union if else while for return x ", 0);
      add_text("== != <= >= << >> && || -> = ! @ 0 0x 0XaF 65536 99999 ", 0);
      add_text("'a' '\\n' '\\t' '\\r' '\\0' '\\q' ''' \"s\\\"t\" ", 0);
      add_text("// line\n# pre\n/* bl**k */ returns abcdefgh_9 /", 1);
      add_text("\"open", 1);
      add_text("'\\", 1);
      add_text("/* open", 1);
      pending_bytes.push_back('{8'd255, 1'b0});
      pending_bytes.push_back('{8'd0, 1'b0});
      add_text("<", 1);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase
         if (phase == 2) hold_start = 1'b1;
         while (pending_bytes.size() < 45) add_random_source();
         wait_drained();
      end
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("tb_c_subset_tokenizer OK");
      else $display("tb_c_subset_tokenizer NOT OK");
      $finish;
   end
endmodule

>>> filelist.f
rtl/cst_pkg.sv
rtl/cst_if.sv
rtl/cst_front.sv
rtl/cst_back.sv
rtl/c_subset_tokenizer.sv
test/tb_c_subset_tokenizer.sv
